// ----- hw/rtl/qxm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the quad X motor mixer: payload structs,
// controller states, register indexes and serial datapath sizes. No dependencies.
package qxm_pkg;

   // Field widths
   localparam int CMD_W       = 32;
   localparam int HOVER_W     = 31;
   localparam int ALPHA_W     = 17;
   localparam int GAIN_W      = 31;
   localparam int RPM_GAIN_W  = 32;
   localparam int RPM_W       = 20;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int NUM_TORQUES = 3;
   localparam int LANES       = 4;

   // Serial datapath: two bits retire per cycle in every lane
   localparam int DIGIT_W  = 2;
   localparam int MCAND_W  = 33;
   localparam int MPLIER_W = 32;
   localparam int ACC_W    = 36;
   localparam int PROD_W   = ACC_W + MPLIER_W;
   localparam int STEPS    = MPLIER_W / DIGIT_W;
   localparam int CNT_W    = $clog2(STEPS + 1);
   localparam int RAD_W    = 64;
   localparam int ROOT_W   = 32;
   localparam int REM_W    = 36;
   localparam int SUM_W    = 51;
   localparam int SQRT_PRESHIFT = 12;

   // Binary point positions of the three product kinds
   localparam int LAG_SHIFT = 16;
   localparam int MIX_SHIFT = 14;
   localparam int RPM_SHIFT = 31;

   // Half-up rounding offsets, preloaded into the accumulator
   localparam logic [ACC_W-1:0] LAG_RND = ACC_W'(1) << (LAG_SHIFT - 1);
   localparam logic [ACC_W-1:0] MIX_RND = ACC_W'(1) << (MIX_SHIFT - 1);
   localparam logic [ACC_W-1:0] RPM_RND = ACC_W'(1) << (RPM_SHIFT - 1);

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);
   localparam logic [RPM_W-1:0]   RPM_MAX   = '1;

   // Register reset values
   localparam logic [HOVER_W-1:0]    HOVER_RST     = '0;
   localparam logic [ALPHA_W-1:0]    ALPHA_RST     = ALPHA_W'(6554);
   localparam logic [GAIN_W-1:0]     RP_GAIN_RST   = GAIN_W'(102963);
   localparam logic [GAIN_W-1:0]     YAW_GAIN_RST  = GAIN_W'(428284);
   localparam logic [RPM_GAIN_W-1:0] RPM_GAIN_RST  = RPM_GAIN_W'(362531000);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HOVER_THRUST    = 3'd0,
      CSR_THRUST_ALPHA    = 3'd1,
      CSR_TORQUE_ALPHA    = 3'd2,
      CSR_ROLL_PITCH_GAIN = 3'd3,
      CSR_YAW_GAIN        = 3'd4,
      CSR_RPM_GAIN        = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LAG,
      ST_MIX,
      ST_SUM,
      ST_SQRT,
      ST_RPM,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } lane_ctl_type;

   typedef struct packed {
      logic signed [CMD_W-1:0] thrust_cmd;
      logic                    thrust_cmd_new;
      logic signed [CMD_W-1:0] torque_roll_cmd;
      logic signed [CMD_W-1:0] torque_pitch_cmd;
      logic signed [CMD_W-1:0] torque_yaw_cmd;
   } req_type;

   typedef struct packed {
      logic [RPM_W-1:0] rpm_front_right;
      logic [RPM_W-1:0] rpm_rear_left;
      logic [RPM_W-1:0] rpm_front_left;
      logic [RPM_W-1:0] rpm_rear_right;
      logic             rpm_valid;
      logic             rpm_saturated;
   } rsp_type;

endpackage

// ----- hw/rtl/quad_x_motor_mixer_rpm_top.sv -----
`timescale 1ns / 1ps
// Quad X-frame motor mixer: thrust and torque lag filters, X mixing and
// rotor speed from the square root of force. Uses qxm_pkg, qxm_mul_lane
// and qxm_sqrt_lane.
//
//   channel   ports                                  beat
//   -------   -------------------------------------  -------------------------
//   req       req_valid  req_ready  req_data         one control tick (req_type)
//   rsp       rsp_valid  rsp_ready  rsp_data         four rotor speeds (rsp_type)
//   csr       csr_valid  csr_ready  csr_index/wdata  one register write
//
// Sequence: a tick runs from one req beat to the next through the accept
//   state, four serial passes (lag multiply, mix multiply, square root,
//   speed multiply), the mix-sum state and the output state. The passes
//   run on the four radix-4 shift-add lanes and the four 2-bit square
//   root lanes; the result register loads in the output state.
// Reset: synchronous, active high; registers return to their defaults,
//   filter state and the thrust-seen flag clear.
// Stalls: a new req beat is taken while the last result still waits on rsp;
//   the output cycle holds until the rsp register is free. csr is always ready.
module quad_x_motor_mixer_rpm_top
   import qxm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // ---------------------------------------------------------------- registers
   logic [HOVER_W-1:0]    hover_ff,     hover_in;
   logic [ALPHA_W-1:0]    thr_alpha_ff, thr_alpha_in;
   logic [ALPHA_W-1:0]    tq_alpha_ff,  tq_alpha_in;
   logic [GAIN_W-1:0]     rp_gain_ff,   rp_gain_in;
   logic [GAIN_W-1:0]     yaw_gain_ff,  yaw_gain_in;
   logic [RPM_GAIN_W-1:0] rpm_gain_ff,  rpm_gain_in;

   // Controller
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff,   cnt_in;
   logic              cnt_zero;
   logic              cnt_end;
   logic              pass_run;

   // Filter state and latched tick
   logic              seen_ff, seen_in;
   logic [CMD_W-1:0]  held_ff, held_in;
   logic [CMD_W-1:0]  ft_ff,   ft_in;
   logic [CMD_W-1:0]  tq_ff   [NUM_TORQUES];
   logic [CMD_W-1:0]  tq_in   [NUM_TORQUES];
   logic [CMD_W-1:0]  tcmd_ff [NUM_TORQUES];
   logic [CMD_W-1:0]  tcmd_in [NUM_TORQUES];
   logic [SUM_W-1:0]  sum_ff  [LANES];
   logic [SUM_W-1:0]  sum_in  [LANES];

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff,  rsp_data_in;

   // Controller outputs
   lane_ctl_type      mul_ctl;
   lane_ctl_type      sqrt_ctl;
   logic              filt_wr;
   logic              sum_wr;
   logic              rsp_wr;

   // Lane operands and results
   logic [MCAND_W-1:0]  mcand_sel  [LANES];
   logic [MPLIER_W-1:0] mplier_sel [LANES];
   logic [ACC_W-1:0]    init_sel;
   logic [PROD_W-1:0]   prod       [LANES];
   logic [RAD_W-1:0]    radicand   [LANES];
   logic [ROOT_W-1:0]   root       [LANES];

   // Datapath intermediates
   logic [ALPHA_W-1:0]  thr_alpha_eff;
   logic [ALPHA_W-1:0]  tq_alpha_eff;
   logic [CMD_W-1:0]    ft_new;
   logic [CMD_W-1:0]    tq_new  [NUM_TORQUES];
   logic [SUM_W-1:0]    thrust_ext;
   logic [SUM_W-1:0]    force_w [LANES];
   logic [RPM_W-1:0]    rpm_w   [LANES];
   logic [LANES-1:0]    sat_w;

   // ---------------------------------------------------------------- config port
   assign csr_ready = 1'b1;

   always_comb begin
      hover_in     = hover_ff;
      thr_alpha_in = thr_alpha_ff;
      tq_alpha_in  = tq_alpha_ff;
      rp_gain_in   = rp_gain_ff;
      yaw_gain_in  = yaw_gain_ff;
      rpm_gain_in  = rpm_gain_ff;
      if (csr_valid && csr_ready) begin
         // indexes past the last register drop the write
         unique case (csr_index)
            CSR_HOVER_THRUST:    hover_in     = csr_wdata[HOVER_W-1:0];
            CSR_THRUST_ALPHA:    thr_alpha_in = csr_wdata[ALPHA_W-1:0];
            CSR_TORQUE_ALPHA:    tq_alpha_in  = csr_wdata[ALPHA_W-1:0];
            CSR_ROLL_PITCH_GAIN: rp_gain_in   = csr_wdata[GAIN_W-1:0];
            CSR_YAW_GAIN:        yaw_gain_in  = csr_wdata[GAIN_W-1:0];
            CSR_RPM_GAIN:        rpm_gain_in  = csr_wdata[RPM_GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // An alpha above one acts as exactly one
   assign thr_alpha_eff = thr_alpha_ff[ALPHA_W-1] ? ALPHA_ONE : thr_alpha_ff;
   assign tq_alpha_eff  = tq_alpha_ff[ALPHA_W-1]  ? ALPHA_ONE : tq_alpha_ff;

   // ---------------------------------------------------------------- controller
   assign cnt_zero = (cnt_ff == '0);
   assign cnt_end  = (cnt_ff == CNT_W'(STEPS));
   assign pass_run = (state_ff == ST_LAG) || (state_ff == ST_MIX) ||
                     (state_ff == ST_SQRT) || (state_ff == ST_RPM);

   // Each pass: count zero loads the lanes, counts 1 to STEPS shift the digits
   assign cnt_in = (pass_run && !cnt_end) ? cnt_ff + CNT_W'(1) : '0;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid)                   state_in = ST_LAG;
         ST_LAG:  if (cnt_end)                     state_in = ST_MIX;
         ST_MIX:  if (cnt_end)                     state_in = ST_SUM;
         ST_SUM:                                   state_in = ST_SQRT;
         ST_SQRT: if (cnt_end)                     state_in = ST_RPM;
         ST_RPM:  if (cnt_end)                     state_in = ST_DONE;
         ST_DONE: if (!rsp_valid_ff || rsp_ready)  state_in = ST_IDLE;
         default:                                  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      mul_ctl   = '0;
      sqrt_ctl  = '0;
      filt_wr   = 1'b0;
      sum_wr    = 1'b0;
      rsp_wr    = 1'b0;
      unique case (state_ff) inside
         ST_IDLE: req_ready = 1'b1;
         ST_LAG, ST_RPM: begin
            mul_ctl.load = cnt_zero;
            mul_ctl.step = !cnt_zero;
         end
         ST_MIX: begin
            // lag results land in the filter state as the mix pass loads
            filt_wr      = cnt_zero;
            mul_ctl.load = cnt_zero;
            mul_ctl.step = !cnt_zero;
         end
         ST_SUM:  sum_wr = 1'b1;
         ST_SQRT: begin
            sqrt_ctl.load = cnt_zero;
            sqrt_ctl.step = !cnt_zero;
         end
         ST_DONE: rsp_wr = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- filters
   // Lag step: x += (alpha * (cmd - x) + half) >>> 16, taken from the lane product
   always_comb begin
      ft_new = seen_ff ? ft_ff + prod[0][LAG_SHIFT +: CMD_W] : CMD_W'(hover_ff);
      for (int k = 0; k < NUM_TORQUES; k++) begin
         tq_new[k] = tq_ff[k] + prod[k + 1][LAG_SHIFT +: CMD_W];
      end
   end

   always_comb begin
      seen_in = seen_ff;
      held_in = held_ff;
      ft_in   = ft_ff;
      tq_in   = tq_ff;
      tcmd_in = tcmd_ff;
      if (req_valid && req_ready) begin
         // latch the torques and any flagged thrust command before this tick filters
         tcmd_in[0] = req_data.torque_roll_cmd;
         tcmd_in[1] = req_data.torque_pitch_cmd;
         tcmd_in[2] = req_data.torque_yaw_cmd;
         if (req_data.thrust_cmd_new) begin
            held_in = req_data.thrust_cmd;
            seen_in = 1'b1;
         end
      end
      if (filt_wr) begin
         ft_in = ft_new;
         tq_in = tq_new;
      end
   end

   // ---------------------------------------------------------------- lane operands
   always_comb begin
      init_sel = '0;
      for (int k = 0; k < LANES; k++) begin
         mcand_sel[k]  = '0;
         mplier_sel[k] = '0;
      end
      unique case (state_ff)
         ST_LAG: begin
            init_sel      = LAG_RND;
            mcand_sel[0]  = {held_ff[CMD_W-1], held_ff} - {ft_ff[CMD_W-1], ft_ff};
            mplier_sel[0] = MPLIER_W'(thr_alpha_eff);
            for (int k = 0; k < NUM_TORQUES; k++) begin
               mcand_sel[k + 1]  = {tcmd_ff[k][CMD_W-1], tcmd_ff[k]} -
                                   {tq_ff[k][CMD_W-1], tq_ff[k]};
               mplier_sel[k + 1] = MPLIER_W'(tq_alpha_eff);
            end
         end
         ST_MIX: begin
            // lanes 0..2: roll, pitch, yaw products; lane 3 idles
            init_sel = MIX_RND;
            for (int k = 0; k < NUM_TORQUES; k++) begin
               mcand_sel[k] = {tq_new[k][CMD_W-1], tq_new[k]};
            end
            mplier_sel[0] = MPLIER_W'(rp_gain_ff);
            mplier_sel[1] = MPLIER_W'(rp_gain_ff);
            mplier_sel[2] = MPLIER_W'(yaw_gain_ff);
         end
         ST_RPM: begin
            init_sel = RPM_RND;
            for (int k = 0; k < LANES; k++) begin
               mcand_sel[k]  = {1'b0, rpm_gain_ff};
               mplier_sel[k] = root[k];
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- mixing
   // Split the four-term sums: t -/+ yaw, roll +/- pitch, one add each cycle
   assign thrust_ext = {{(SUM_W - CMD_W){ft_ff[CMD_W-1]}}, ft_ff};

   always_comb begin
      sum_in = sum_ff;
      if (sum_wr) begin
         sum_in[0] = thrust_ext - prod[2][MIX_SHIFT +: SUM_W];
         sum_in[1] = thrust_ext + prod[2][MIX_SHIFT +: SUM_W];
         sum_in[2] = prod[0][MIX_SHIFT +: SUM_W] + prod[1][MIX_SHIFT +: SUM_W];
         sum_in[3] = prod[0][MIX_SHIFT +: SUM_W] - prod[1][MIX_SHIFT +: SUM_W];
      end
   end

   // Rotor forces; a force at or below zero gives a zero radicand
   always_comb begin
      force_w[0] = sum_ff[0] - sum_ff[2];
      force_w[1] = sum_ff[0] + sum_ff[2];
      force_w[2] = sum_ff[1] + sum_ff[3];
      force_w[3] = sum_ff[1] - sum_ff[3];
      for (int k = 0; k < LANES; k++) begin
         radicand[k] = force_w[k][SUM_W-1] ? '0 :
                       RAD_W'({force_w[k][SUM_W-2:0], {SQRT_PRESHIFT{1'b0}}});
      end
   end

   // ---------------------------------------------------------------- lanes
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      qxm_mul_lane u_mul (
         .clock    (clock),
         .ctl      (mul_ctl),
         .mcand    (mcand_sel[g]),
         .mplier   (mplier_sel[g]),
         .init_acc (init_sel),
         .prod     (prod[g])
      );

      qxm_sqrt_lane u_sqrt (
         .clock    (clock),
         .ctl      (sqrt_ctl),
         .radicand (radicand[g]),
         .root     (root[g])
      );
   end

   // ---------------------------------------------------------------- result
   // Speed is (gain * root + half) >> 31; anything above 20 bits saturates
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         sat_w[k] = |prod[k][PROD_W-1:RPM_SHIFT + RPM_W];
         rpm_w[k] = sat_w[k] ? RPM_MAX : prod[k][RPM_SHIFT +: RPM_W];
      end
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (rsp_wr) begin
         rsp_valid_in = 1'b1;
         if (seen_ff) begin
            rsp_data_in.rpm_front_right = rpm_w[0];
            rsp_data_in.rpm_rear_left   = rpm_w[1];
            rsp_data_in.rpm_front_left  = rpm_w[2];
            rsp_data_in.rpm_rear_right  = rpm_w[3];
            rsp_data_in.rpm_valid       = 1'b1;
            rsp_data_in.rpm_saturated   = |sat_w;
         end else begin
            // no thrust command yet: drop the speeds
            rsp_data_in = '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- flops
   always_ff @(posedge clock) begin
      if (reset) begin
         hover_ff     <= HOVER_RST;
         thr_alpha_ff <= ALPHA_RST;
         tq_alpha_ff  <= ALPHA_RST;
         rp_gain_ff   <= RP_GAIN_RST;
         yaw_gain_ff  <= YAW_GAIN_RST;
         rpm_gain_ff  <= RPM_GAIN_RST;
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         seen_ff      <= 1'b0;
         held_ff      <= '0;
         ft_ff        <= '0;
         for (int k = 0; k < NUM_TORQUES; k++) begin
            tq_ff[k] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         hover_ff     <= hover_in;
         thr_alpha_ff <= thr_alpha_in;
         tq_alpha_ff  <= tq_alpha_in;
         rp_gain_ff   <= rp_gain_in;
         yaw_gain_ff  <= yaw_gain_in;
         rpm_gain_ff  <= rpm_gain_in;
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         seen_ff      <= seen_in;
         held_ff      <= held_in;
         ft_ff        <= ft_in;
         tq_ff        <= tq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tcmd_ff     <= tcmd_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(STEPS))
      else $error("pass counter ran past the last step");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && state_in == ST_IDLE) |=> rsp_valid_ff)
      else $error("tick finished without a result beat");

   a_unseen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.rpm_valid) |->
         (rsp_data.rpm_saturated == 1'b0 && rsp_data.rpm_front_right == '0 &&
          rsp_data.rpm_rear_left == '0 && rsp_data.rpm_front_left == '0 &&
          rsp_data.rpm_rear_right == '0))
      else $error("speeds reported before the first thrust command");

   a_sat_at_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.rpm_saturated) |->
         (rsp_data.rpm_front_right == RPM_MAX || rsp_data.rpm_rear_left == RPM_MAX ||
          rsp_data.rpm_front_left == RPM_MAX || rsp_data.rpm_rear_right == RPM_MAX))
      else $error("saturation flagged with no rotor at full scale");
`endif

endmodule

// ----- hw/rtl/qxm_mul_lane.sv -----
`timescale 1ns / 1ps
// Digit-serial shift-add multiplier lane: signed multiplicand times unsigned
// multiplier, two multiplier bits per cycle while stepping, LSB first. Uses qxm_pkg.
module qxm_mul_lane
   import qxm_pkg::*;
(
   input  logic                clock,
   input  lane_ctl_type        ctl,
   input  logic [MCAND_W-1:0]  mcand,
   input  logic [MPLIER_W-1:0] mplier,
   input  logic [ACC_W-1:0]    init_acc,
   output logic [PROD_W-1:0]   prod
);

   logic [MCAND_W-1:0]  mcand_ff,  mcand_in;
   logic [MPLIER_W-1:0] mplier_ff, mplier_in;
   logic [ACC_W-1:0]    acc_ff,    acc_in;
   logic [MPLIER_W-1:0] low_ff,    low_in;

   logic [ACC_W-1:0] mcand_ext;
   logic [ACC_W-1:0] pp_w;
   logic [ACC_W-1:0] sum_w;

   // Partial product of one digit, added into the running high half
   always_comb begin
      mcand_ext = {{(ACC_W - MCAND_W){mcand_ff[MCAND_W-1]}}, mcand_ff};
      pp_w      = '0;
      for (int b = 0; b < DIGIT_W; b++) begin
         if (mplier_ff[b]) begin
            pp_w = pp_w + (mcand_ext << b);
         end
      end
      sum_w = acc_ff + pp_w;
   end

   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      low_in    = low_ff;
      if (ctl.load) begin
         mcand_in  = mcand;
         mplier_in = mplier;
         acc_in    = init_acc;
         low_in    = '0;
      end else if (ctl.step) begin
         // shift the finished low digit out into the low half
         mplier_in = {{DIGIT_W{1'b0}}, mplier_ff[MPLIER_W-1:DIGIT_W]};
         acc_in    = {{DIGIT_W{sum_w[ACC_W-1]}}, sum_w[ACC_W-1:DIGIT_W]};
         low_in    = {sum_w[DIGIT_W-1:0], low_ff[MPLIER_W-1:DIGIT_W]};
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      low_ff    <= low_in;
   end

   assign prod = {acc_ff, low_ff};

endmodule

// ----- hw/rtl/qxm_sqrt_lane.sv -----
`timescale 1ns / 1ps
// Digit-serial integer square root lane: restoring method, two root bits
// per cycle while stepping, radicand shifted in from the top. Uses qxm_pkg.
module qxm_sqrt_lane
   import qxm_pkg::*;
(
   input  logic              clock,
   input  lane_ctl_type      ctl,
   input  logic [RAD_W-1:0]  radicand,
   output logic [ROOT_W-1:0] root
);

   logic [RAD_W-1:0]  rad_ff,  rad_in;
   logic [REM_W-1:0]  rem_ff,  rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;

   logic [RAD_W-1:0]  rad_w;
   logic [REM_W-1:0]  rem_w;
   logic [REM_W-1:0]  trial_w;
   logic [ROOT_W-1:0] root_w;

   always_comb begin
      rad_w   = rad_ff;
      rem_w   = rem_ff;
      root_w  = root_ff;
      trial_w = '0;
      for (int i = 0; i < DIGIT_W; i++) begin
         // bring down two radicand bits, try 4*root+1
         rem_w   = {rem_w[REM_W-3:0], rad_w[RAD_W-1 -: 2]};
         rad_w   = {rad_w[RAD_W-3:0], 2'b00};
         trial_w = REM_W'({root_w, 2'b01});
         if (rem_w >= trial_w) begin
            rem_w  = rem_w - trial_w;
            root_w = {root_w[ROOT_W-2:0], 1'b1};
         end else begin
            root_w = {root_w[ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (ctl.load) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (ctl.step) begin
         rad_in  = rad_w;
         rem_in  = rem_w;
         root_in = root_w;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;

endmodule

// ----- verif/quad_x_motor_mixer_rpm_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for quad_x_motor_mixer_rpm_top: tick driver, rotor speed monitor
// and an in-bench model of the lag filters, X mixing and square-root speed stage.
// Depends on qxm_pkg and the RTL under hw/rtl only.
module quad_x_motor_mixer_rpm_top_tb
   import qxm_pkg::*;
();

   // Spare register slots: writes there must leave every register untouched
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   localparam int NEWTON       = 65536;              // 1.0 in Q16.16
   localparam logic signed [CMD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [CMD_W-1:0] Q_MIN = 32'sh8000_0000;
   localparam int SETTLE_CYCLES = 80;
   localparam int HOLD_CYCLES   = 600;               // long receiver hold-off
   localparam int REPORT_LIMIT  = 10;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Pending ticks, fed by the stimulus process and drained by the driver
   req_type tick_queue[$];
   // Predicted rotor speeds, oldest first
   rsp_type rpm_expect_q[$];

   int ticks_issued = 0;
   int speeds_seen  = 0;
   int fail_count   = 0;
   int send_gap     = 0;
   int recv_gap     = 0;
   bit quiet_tail   = 1'b0;
   bit hold_armed   = 1'b0;
   logic rsp_hold   = 1'b0;

   // Mixer model: register copies and filter state
   logic [HOVER_W-1:0]    cfg_hover;
   logic [ALPHA_W-1:0]    cfg_thrust_alpha;
   logic [ALPHA_W-1:0]    cfg_torque_alpha;
   logic [GAIN_W-1:0]     cfg_rp_gain;
   logic [GAIN_W-1:0]     cfg_yaw_gain;
   logic [RPM_GAIN_W-1:0] cfg_rpm_gain;
   logic signed [CMD_W-1:0] flt_thrust;
   logic signed [CMD_W-1:0] flt_torque [NUM_TORQUES];
   logic signed [CMD_W-1:0] held_thrust;
   logic                    cmd_latched;

   quad_x_motor_mixer_rpm_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // Model arithmetic
   // ---------------------------------------------------------------------

   // One first-order lag step, half-up rounding; alpha saturates at one
   function automatic logic signed [CMD_W-1:0] lag_step(input longint x, input longint cmd,
                                                        input logic [ALPHA_W-1:0] alpha);
      longint a;
      a = longint'((alpha > ALPHA_ONE) ? ALPHA_ONE : alpha);
      return CMD_W'(x + ((a * (cmd - x) + (longint'(1) <<< (LAG_SHIFT - 1))) >>> LAG_SHIFT));
   endfunction

   // Gain times torque, rounded half up into the Q.18 force domain
   function automatic longint mix_term(input longint gain, input longint torque);
      return (gain * torque + (longint'(1) <<< (MIX_SHIFT - 1))) >>> MIX_SHIFT;
   endfunction

   // Floor square root, one result bit per pass from the top
   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned r;
      longint unsigned trial;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
         trial = r | (longint'(1) << i);
         if (trial * trial <= v)
            r = trial;
      end
      return r;
   endfunction

   // Rotor speed from a Q.18 force; top bit flags clipping
   function automatic logic [RPM_W:0] rotor_rpm(input longint f);
      longint unsigned root;
      longint unsigned prod;
      longint unsigned r;
      if (f <= 0)
         return '0;
      root = floor_root(longint'(f) << SQRT_PRESHIFT);
      prod = cfg_rpm_gain * root;
      r    = ((prod >> (RPM_SHIFT - 1)) + 1) >> 1;
      if (r > RPM_MAX)
         return {1'b1, RPM_MAX};
      return {1'b0, r[RPM_W-1:0]};
   endfunction

   // Advance the model by one control tick and return the rotor speeds
   function automatic rsp_type advance_mixer(input req_type tick);
      rsp_type         out;
      longint          t;
      longint          rx;
      longint          ry;
      longint          yz;
      longint          force_q18 [LANES];
      logic [RPM_W:0]  lane [LANES];
      out = '0;
      // latch first, then filter on the same tick
      if (tick.thrust_cmd_new) begin
         held_thrust = tick.thrust_cmd;
         cmd_latched = 1'b1;
      end
      if (cmd_latched)
         flt_thrust = lag_step(longint'(flt_thrust), longint'(held_thrust), cfg_thrust_alpha);
      else
         flt_thrust = CMD_W'(cfg_hover);
      flt_torque[0] = lag_step(longint'(flt_torque[0]), longint'(tick.torque_roll_cmd),
                               cfg_torque_alpha);
      flt_torque[1] = lag_step(longint'(flt_torque[1]), longint'(tick.torque_pitch_cmd),
                               cfg_torque_alpha);
      flt_torque[2] = lag_step(longint'(flt_torque[2]), longint'(tick.torque_yaw_cmd),
                               cfg_torque_alpha);
      if (!cmd_latched)
         return out;

      // Q16.16 thrust read as Q.18 is a quarter of the collective
      t  = longint'(flt_thrust);
      rx = mix_term(longint'(cfg_rp_gain), longint'(flt_torque[0]));
      ry = mix_term(longint'(cfg_rp_gain), longint'(flt_torque[1]));
      yz = mix_term(longint'(cfg_yaw_gain), longint'(flt_torque[2]));
      force_q18[0] = t - rx - ry - yz;
      force_q18[1] = t + rx + ry - yz;
      force_q18[2] = t + rx - ry + yz;
      force_q18[3] = t - rx + ry + yz;
      for (int k = 0; k < LANES; k++)
         lane[k] = rotor_rpm(force_q18[k]);

      out.rpm_front_right = lane[0][RPM_W-1:0];
      out.rpm_rear_left   = lane[1][RPM_W-1:0];
      out.rpm_front_left  = lane[2][RPM_W-1:0];
      out.rpm_rear_right  = lane[3][RPM_W-1:0];
      out.rpm_valid       = 1'b1;
      out.rpm_saturated   = lane[0][RPM_W] | lane[1][RPM_W] | lane[2][RPM_W] | lane[3][RPM_W];
      return out;
   endfunction

   // Mirror a register write into the model; spare slots drop the data
   function automatic void apply_reg(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_HOVER_THRUST:    cfg_hover        = value[HOVER_W-1:0];
         CSR_THRUST_ALPHA:    cfg_thrust_alpha = value[ALPHA_W-1:0];
         CSR_TORQUE_ALPHA:    cfg_torque_alpha = value[ALPHA_W-1:0];
         CSR_ROLL_PITCH_GAIN: cfg_rp_gain      = value[GAIN_W-1:0];
         CSR_YAW_GAIN:        cfg_yaw_gain     = value[GAIN_W-1:0];
         CSR_RPM_GAIN:        cfg_rpm_gain     = value[RPM_GAIN_W-1:0];
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic req_type mk_tick(input logic signed [CMD_W-1:0] thrust, input logic fresh,
                                       input logic signed [CMD_W-1:0] roll,
                                       input logic signed [CMD_W-1:0] pitch,
                                       input logic signed [CMD_W-1:0] yaw);
      req_type t;
      t.thrust_cmd       = thrust;
      t.thrust_cmd_new   = fresh;
      t.torque_roll_cmd  = roll;
      t.torque_pitch_cmd = pitch;
      t.torque_yaw_cmd   = yaw;
      return t;
   endfunction

   function automatic logic signed [CMD_W-1:0] corner_value();
      case ($urandom_range(0, 4))
         0:       return Q_MAX;
         1:       return Q_MIN;
         2:       return '0;
         3:       return -1;
         default: return 1;
      endcase
   endfunction

   // Mostly flight-like ticks, the rest full-range noise and corners
   function automatic req_type random_tick();
      req_type t;
      int      kind;
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
         t.thrust_cmd       = int'($urandom_range(0, 45 * NEWTON)) - 5 * NEWTON;
         t.torque_roll_cmd  = int'($urandom_range(0, 4 * NEWTON)) - 2 * NEWTON;
         t.torque_pitch_cmd = int'($urandom_range(0, 4 * NEWTON)) - 2 * NEWTON;
         t.torque_yaw_cmd   = int'($urandom_range(0, NEWTON)) - NEWTON / 2;
      end else if (kind < 8) begin
         t.thrust_cmd       = $urandom;
         t.torque_roll_cmd  = $urandom;
         t.torque_pitch_cmd = $urandom;
         t.torque_yaw_cmd   = $urandom;
      end else begin
         t.thrust_cmd       = corner_value();
         t.torque_roll_cmd  = corner_value();
         t.torque_pitch_cmd = corner_value();
         t.torque_yaw_cmd   = corner_value();
      end
      t.thrust_cmd_new = 1'($urandom_range(0, 1));
      return t;
   endfunction

   // Alpha in the low bits, junk above them to prove the masking
   function automatic logic [CSR_DATA_W-1:0] pick_alpha();
      logic [ALPHA_W-1:0] a;
      case ($urandom_range(0, 3))
         0:       a = ALPHA_W'($urandom_range(0, 65536));
         1:       a = ALPHA_W'($urandom_range(65537, 131071));
         2:       a = ALPHA_W'($urandom_range(1000, 20000));
         default: a = ALPHA_ONE;
      endcase
      return ($urandom & 32'hFFFE_0000) | CSR_DATA_W'(a);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_gain(input logic [CSR_DATA_W-1:0] nominal);
      if ($urandom_range(0, 2) == 0)
         return $urandom;
      return $urandom_range(nominal / 2, nominal * 2);
   endfunction

   // Hold one csr beat until taken; enter and leave on a rising edge
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_defaults();
      write_reg(CSR_HOVER_THRUST, CSR_DATA_W'(HOVER_RST));
      write_reg(CSR_THRUST_ALPHA, CSR_DATA_W'(ALPHA_RST));
      write_reg(CSR_TORQUE_ALPHA, CSR_DATA_W'(ALPHA_RST));
      write_reg(CSR_ROLL_PITCH_GAIN, CSR_DATA_W'(RP_GAIN_RST));
      write_reg(CSR_YAW_GAIN, CSR_DATA_W'(YAW_GAIN_RST));
      write_reg(CSR_RPM_GAIN, CSR_DATA_W'(RPM_GAIN_RST));
   endtask

   task automatic shuffle_registers();
      if ($urandom_range(0, 1)) write_reg(CSR_HOVER_THRUST, $urandom);
      if ($urandom_range(0, 1)) write_reg(CSR_THRUST_ALPHA, pick_alpha());
      if ($urandom_range(0, 1)) write_reg(CSR_TORQUE_ALPHA, pick_alpha());
      if ($urandom_range(0, 1))
         write_reg(CSR_ROLL_PITCH_GAIN, pick_gain(CSR_DATA_W'(RP_GAIN_RST)));
      if ($urandom_range(0, 1)) write_reg(CSR_YAW_GAIN, pick_gain(CSR_DATA_W'(YAW_GAIN_RST)));
      if ($urandom_range(0, 1)) write_reg(CSR_RPM_GAIN, pick_gain(RPM_GAIN_RST));
      if ($urandom_range(0, 3) == 0)
         write_reg($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B, $urandom);
   endtask

   task automatic offer(input req_type t);
      tick_queue.insert(tick_queue.size(), t);
      ticks_issued++;
   endtask

   // Wait until every tick has produced its speeds, then let the block settle
   task automatic drain();
      while (speeds_seen < ticks_issued)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_batch(input int count);
      for (int i = 0; i < count; i++)
         offer(random_tick());
      drain();
   endtask

   task automatic flag_error(input string what);
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
         $display("%s", what);
   endtask

   // ---------------------------------------------------------------------
   // Driver: offer queued ticks, predict on each accepted beat
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            rpm_expect_q.insert(rpm_expect_q.size(), advance_mixer(req_data));
            void'(tick_queue.pop_front());
         end
         // Hold the offer while it waits; otherwise pick the next one
         if (!req_valid || req_ready) begin
            if (send_gap == 0 && !quiet_tail && $urandom_range(0, 5) == 0)
               send_gap = $urandom_range(1, 7);
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
               req_valid <= 1'b0;
            end else if (tick_queue.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= tick_queue[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: check each rsp beat against the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            speeds_seen++;
            if (rpm_expect_q.size() == 0) begin
               flag_error($sformatf("unexpected rsp beat %0d: %h", speeds_seen, got));
            end else begin
               want = rpm_expect_q.pop_front();
               if (got.rpm_front_right !== want.rpm_front_right ||
                   got.rpm_rear_left   !== want.rpm_rear_left   ||
                   got.rpm_front_left  !== want.rpm_front_left  ||
                   got.rpm_rear_right  !== want.rpm_rear_right  ||
                   got.rpm_valid       !== want.rpm_valid       ||
                   got.rpm_saturated   !== want.rpm_saturated)
                  flag_error($sformatf({"rpm mismatch on beat %0d: exp fr=%0d rl=%0d fl=%0d ",
                                        "rr=%0d v=%b s=%b, got fr=%0d rl=%0d fl=%0d rr=%0d ",
                                        "v=%b s=%b"}, speeds_seen,
                                       want.rpm_front_right, want.rpm_rear_left,
                                       want.rpm_front_left, want.rpm_rear_right,
                                       want.rpm_valid, want.rpm_saturated,
                                       got.rpm_front_right, got.rpm_rear_left,
                                       got.rpm_front_left, got.rpm_rear_right,
                                       got.rpm_valid, got.rpm_saturated));
            end
         end
         // Stall in short random bursts, or for the long hold-off
         if (rsp_hold) begin
            rsp_ready <= 1'b0;
         end else begin
            if (recv_gap == 0 && !quiet_tail && $urandom_range(0, 7) == 0)
               recv_gap = $urandom_range(1, 7);
            if (recv_gap > 0) begin
               recv_gap = recv_gap - 1;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   // Long receiver hold-off: the sender keeps offering, so the block fills
   // its result register, finishes the next tick and then stalls req.
   initial begin
      wait (hold_armed);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin
      cfg_hover        = HOVER_RST;
      cfg_thrust_alpha = ALPHA_RST;
      cfg_torque_alpha = ALPHA_RST;
      cfg_rp_gain      = RP_GAIN_RST;
      cfg_yaw_gain     = YAW_GAIN_RST;
      cfg_rpm_gain     = RPM_GAIN_RST;
      flt_thrust       = '0;
      flt_torque[0]    = '0;
      flt_torque[1]    = '0;
      flt_torque[2]    = '0;
      held_thrust      = '0;
      cmd_latched      = 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Before any thrust command: speeds stay zero, torques still filter
      offer(mk_tick('0, 1'b0, '0, '0, '0));
      offer(mk_tick(Q_MAX, 1'b0, Q_MAX, Q_MAX, Q_MAX));
      drain();
      // Hover at its ceiling; bit 31 of the write must drop
      write_reg(CSR_HOVER_THRUST, 32'hFFFF_FFFF);
      offer(mk_tick(Q_MIN, 1'b0, Q_MIN, Q_MIN, Q_MIN));
      // First command: latched and filtered on the same tick
      offer(mk_tick(10 * NEWTON, 1'b1, '0, '0, '0));
      // Unflagged command: keep the held one
      offer(mk_tick(Q_MIN, 1'b0, NEWTON, -NEWTON, NEWTON / 4));
      offer(mk_tick(Q_MAX, 1'b1, '0, '0, '0));
      offer(mk_tick(Q_MAX, 1'b1, '0, '0, '0));
      // Negative collective: forces clamp to zero speed
      offer(mk_tick(Q_MIN, 1'b1, '0, '0, '0));
      offer(mk_tick(Q_MIN, 1'b1, '0, '0, '0));
      offer(mk_tick(15 * NEWTON, 1'b1, Q_MAX, Q_MIN, '0));
      offer(mk_tick(15 * NEWTON, 1'b1, Q_MIN, Q_MAX, Q_MAX));
      offer(mk_tick(15 * NEWTON, 1'b0, '0, '0, Q_MIN));
      offer(mk_tick(-1, 1'b1, -1, -1, -1));
      offer(mk_tick(1, 1'b1, 1, 1, 1));
      drain();

      // Alpha of one and every gain at its ceiling: heavy saturation
      write_reg(CSR_HOVER_THRUST, 32'h0000_0000);
      write_reg(CSR_THRUST_ALPHA, CSR_DATA_W'(ALPHA_ONE));
      write_reg(CSR_TORQUE_ALPHA, CSR_DATA_W'(ALPHA_ONE));
      write_reg(CSR_ROLL_PITCH_GAIN, 32'hFFFF_FFFF);
      write_reg(CSR_YAW_GAIN, 32'hFFFF_FFFF);
      write_reg(CSR_RPM_GAIN, 32'hFFFF_FFFF);
      run_batch(20);

      // Alpha above one acts as one; zero gains give zero speed
      write_reg(CSR_THRUST_ALPHA, 32'h0001_FFFF);
      write_reg(CSR_TORQUE_ALPHA, 32'h0001_FFFF);
      write_reg(CSR_ROLL_PITCH_GAIN, 32'h0000_0000);
      write_reg(CSR_YAW_GAIN, 32'h0000_0000);
      write_reg(CSR_RPM_GAIN, 32'h0000_0000);
      run_batch(15);

      // Zero alpha freezes the filters; spare slots are ignored
      write_reg(CSR_THRUST_ALPHA, 32'hFFFE_0000);
      write_reg(CSR_TORQUE_ALPHA, 32'hFFFE_0000);
      write_reg(CSR_ROLL_PITCH_GAIN, CSR_DATA_W'(RP_GAIN_RST));
      write_reg(CSR_YAW_GAIN, CSR_DATA_W'(YAW_GAIN_RST));
      write_reg(CSR_RPM_GAIN, CSR_DATA_W'(RPM_GAIN_RST));
      write_reg(CSR_SPARE_A, 32'hFFFF_FFFF);
      write_reg(CSR_SPARE_B, 32'h0000_0001);
      run_batch(15);

      // Random register settings between batches
      load_defaults();
      for (int phase = 0; phase < 8; phase++) begin
         if (phase != 0)
            shuffle_registers();
         if (phase == 2)
            hold_armed = 1'b1;
         run_batch(45);
      end

      // Tail: nominal registers, both sides streaming
      load_defaults();
      quiet_tail = 1'b1;
      run_batch(40);

      if (fail_count == 0 && rpm_expect_q.size() == 0)
         $display("quad_x_motor_mixer_rpm_top_tb passed");
      else
         $display("quad_x_motor_mixer_rpm_top_tb failed");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #1_000_000;
      $display("quad_x_motor_mixer_rpm_top_tb failed");
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/qxm_pkg.sv
hw/rtl/qxm_mul_lane.sv
hw/rtl/qxm_sqrt_lane.sv
hw/rtl/quad_x_motor_mixer_rpm_top.sv
verif/quad_x_motor_mixer_rpm_top_tb.sv
